/* rtl/bufp_pkg.sv */
// shared types and codes for the uart buffer pair
package bufp_pkg;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;

    localparam logic [ACTION_W-1:0] ACT_SEND    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_GET     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RX_BYTE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TX_DONE = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RESET   = 3'd5;

    localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STS_BAD_PORT = 2'd3;

    typedef struct packed {
        logic capture;
        logic commit;
    } bufp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } bufp_sts_t;

endpackage

/* rtl/bufp_ctrl.sv */
// request sequencer: capture, then execute once the result register is free
module bufp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bufp_pkg::bufp_sts_t sts,
    output bufp_pkg::bufp_cmd_t cmd
);
    import bufp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        s_ready     = (state_reg == ST_IDLE);
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!sts.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/bufp_dp.sv */
// ring pointers, byte stores, request decode and result register
module bufp_dp #(
    parameter int DEPTH = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bufp_pkg::bufp_cmd_t           cmd,
    output bufp_pkg::bufp_sts_t           sts,
    input  logic [bufp_pkg::ACTION_W-1:0] s_action,
    input  logic                          s_port,
    input  logic [bufp_pkg::BYTE_W-1:0]   s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bufp_pkg::STATUS_W-1:0] m_status,
    output logic [bufp_pkg::BYTE_W-1:0]   m_byte_out,
    output logic                          m_tx_load,
    output logic                          m_tx_kick
);
    import bufp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        ring_next = (p == LAST) ? '0 : p + 1'b1;
    endfunction

    logic [BYTE_W-1:0] tx_store [DEPTH];
    logic [BYTE_W-1:0] rx_store [DEPTH];

    logic [AW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [AW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic          tx_busy_reg, tx_busy_next;

    logic [ACTION_W-1:0] action_reg;
    logic                port_reg;
    logic [BYTE_W-1:0]   data_reg;
    logic [BYTE_W-1:0]   tx_rd_reg, rx_rd_reg;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic                load_reg, load_next;
    logic                kick_reg, kick_next;

    logic tx_we, rx_we;
    logic tx_full, tx_empty, rx_full, rx_empty;

    assign tx_full  = (ring_next(tx_head_reg) == tx_tail_reg);
    assign tx_empty = (tx_head_reg == tx_tail_reg);
    assign rx_full  = (ring_next(rx_head_reg) == rx_tail_reg);
    assign rx_empty = (rx_head_reg == rx_tail_reg);

    assign sts.out_busy = m_valid_reg && !m_ready;

    always_comb begin
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        tx_busy_next = tx_busy_reg;
        status_next  = STS_OK;
        byte_next    = '0;
        load_next    = 1'b0;
        kick_next    = 1'b0;
        tx_we        = 1'b0;
        rx_we        = 1'b0;
        if (action_reg <= ACT_RESET && port_reg) begin
            status_next = STS_BAD_PORT;
        end else begin
            case (action_reg)
                ACT_SEND: begin
                    if (tx_full) begin
                        status_next = STS_FULL;
                    end else begin
                        tx_we        = 1'b1;
                        tx_head_next = ring_next(tx_head_reg);
                        if (!tx_busy_reg) begin
                            tx_busy_next = 1'b1;
                            kick_next    = 1'b1;
                        end
                    end
                end
                ACT_GET, ACT_PEEK: begin
                    if (rx_empty) begin
                        status_next = STS_EMPTY;
                    end else begin
                        byte_next = rx_rd_reg;
                        if (action_reg == ACT_GET) begin
                            rx_tail_next = ring_next(rx_tail_reg);
                        end
                    end
                end
                ACT_RX_BYTE: begin
                    if (rx_full) begin
                        status_next = STS_FULL;
                    end else begin
                        rx_we        = 1'b1;
                        rx_head_next = ring_next(rx_head_reg);
                    end
                end
                ACT_TX_DONE: begin
                    if (!tx_empty) begin
                        byte_next    = tx_rd_reg;
                        load_next    = 1'b1;
                        tx_tail_next = ring_next(tx_tail_reg);
                    end else begin
                        tx_busy_next = 1'b0;
                        status_next  = STS_EMPTY;
                    end
                end
                ACT_RESET: begin
                    tx_head_next = '0;
                    tx_tail_next = '0;
                    rx_head_next = '0;
                    rx_tail_next = '0;
                    tx_busy_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // byte stores
    always_ff @(posedge aclk) begin
        if (cmd.commit && tx_we) begin
            tx_store[tx_head_reg] <= data_reg;
        end
        if (cmd.capture) begin
            tx_rd_reg <= tx_store[tx_tail_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && rx_we) begin
            rx_store[rx_head_reg] <= data_reg;
        end
        if (cmd.capture) begin
            rx_rd_reg <= rx_store[rx_tail_reg];
        end
    end

    // request capture and result payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= s_action;
            port_reg   <= s_port;
            data_reg   <= s_data;
        end
        if (cmd.commit) begin
            status_reg <= status_next;
            byte_reg   <= byte_next;
            load_reg   <= load_next;
            kick_reg   <= kick_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            tx_busy_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                tx_head_reg <= tx_head_next;
                tx_tail_reg <= tx_tail_next;
                rx_head_reg <= rx_head_next;
                rx_tail_reg <= rx_tail_next;
                tx_busy_reg <= tx_busy_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = status_reg;
    assign m_byte_out = byte_reg;
    assign m_tx_load  = load_reg;
    assign m_tx_kick  = kick_reg;

endmodule

/* rtl/buffered_uart_fifo_pair.sv */
// top level of the uart transmit and receive buffer pair
// Each request (send, get, peek, byte received, transmit complete, reset
// buffers) gives exactly one result. In the cycle a request is accepted
// both ring stores are read at their tail; the request then waits in the
// execute state while an earlier result is still held on m_valid without
// m_ready, and then executes and its result is loaded into the output
// register. So a new request can be accepted while a result waits. Each
// ring has DEPTH entries and holds DEPTH-1 bytes. No clearing pass is
// needed after reset.
module buffered_uart_fifo_pair #(
    parameter int DEPTH = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bufp_pkg::ACTION_W-1:0] s_action,
    input  logic                          s_port,
    input  logic [bufp_pkg::BYTE_W-1:0]   s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bufp_pkg::STATUS_W-1:0] m_status,
    output logic [bufp_pkg::BYTE_W-1:0]   m_byte_out,
    output logic                          m_tx_load,
    output logic                          m_tx_kick
);
    import bufp_pkg::*;

    bufp_cmd_t cmd;
    bufp_sts_t sts;

    bufp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bufp_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_action   (s_action),
        .s_port     (s_port),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_byte_out (m_byte_out),
        .m_tx_load  (m_tx_load),
        .m_tx_kick  (m_tx_kick)
    );

endmodule

/* rtl/bufp_chk.sv */
// port checks for the uart buffer pair, bound to the top level
module bufp_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [bufp_pkg::ACTION_W-1:0] s_action,
    input logic                          s_port,
    input logic [bufp_pkg::BYTE_W-1:0]   s_data,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bufp_pkg::STATUS_W-1:0] m_status,
    input logic [bufp_pkg::BYTE_W-1:0]   m_byte_out,
    input logic                          m_tx_load,
    input logic                          m_tx_kick
);
    import bufp_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_byte_out) && $stable(m_tx_load) && $stable(m_tx_kick))
        else $error("result changed while stalled");

    // kick only on an accepted send, never with a load
    a_kick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_kick |-> m_status == STS_OK && !m_tx_load && m_byte_out == '0)
        else $error("kick with bad status or load");

    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_load |-> m_status == STS_OK)
        else $error("load with bad status");

    // failed requests deliver nothing
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STS_OK |-> m_byte_out == '0 && !m_tx_load && !m_tx_kick)
        else $error("failed request delivered a byte");

endmodule

bind buffered_uart_fifo_pair bufp_chk u_bufp_chk (.*);
